>>> hw/rtl/sfcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcp_pkg
// Shared constants and types for the sync-byte framed checksum parser.
// ----------------------------------------------------------------------------
package sfcp_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned VALUE_W      = 16;
  localparam int unsigned POS_W        = 3;
  localparam int unsigned STORED_BYTES = 5;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;
  localparam logic [BYTE_W-1:0] END_BYTE  = 8'hFF;
  localparam logic [POS_W-1:0]  FIRST_POS = 3'd0;
  localparam logic [POS_W-1:0]  LAST_POS  = 3'd6;

  // Outcome of the word presented to the frame tracker.
  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value;
  } frame_eval_t;

endpackage

>>> hw/rtl/sfcp_frame_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcp_frame_track
// Frame position tracking, byte store and end/checksum test for one word.
// ----------------------------------------------------------------------------
module sfcp_frame_track (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [sfcp_pkg::BYTE_W-1:0] rx_byte,
  output sfcp_pkg::frame_eval_t       eval
);
  import sfcp_pkg::*;

  logic                   in_frame;
  logic [POS_W-1:0]       byte_position;
  logic [BYTE_W-1:0]      frame_bytes [STORED_BYTES];

  logic                   is_sync;
  logic                   active;
  logic [POS_W-1:0]       pos_eff;
  logic                   closing;
  logic [BYTE_W-1:0]      sum;

  assign is_sync = (rx_byte == SYNC_BYTE);
  assign active  = is_sync || in_frame;
  assign pos_eff = is_sync ? FIRST_POS : byte_position;
  assign closing = active && (pos_eff == LAST_POS);
  assign sum     = frame_bytes[0] + frame_bytes[1] + frame_bytes[2] + frame_bytes[3];

  assign eval.hit   = closing && (rx_byte == END_BYTE) && (frame_bytes[4] == sum);
  assign eval.value = {frame_bytes[0], frame_bytes[1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      byte_position <= FIRST_POS;
    end else if (step && active) begin
      if (closing) begin
        in_frame      <= 1'b0;
        byte_position <= FIRST_POS;
      end else begin
        in_frame      <= 1'b1;
        byte_position <= pos_eff + 3'd1;
      end
    end
  end

  // Store bytes 1..5; byte 0 is the sync word itself.
  always_ff @(posedge clk) begin
    if (step && active && !closing && (pos_eff != FIRST_POS)) begin
      frame_bytes[pos_eff - 3'd1] <= rx_byte;
    end
  end

endmodule

>>> hw/rtl/serial_frame_checksum_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_checksum_parser_core
// Receives serial bytes, tracks 7-byte frames opened by a sync word and
// emits byte1:byte2 of every frame that passes the end-byte and sum test.
// ----------------------------------------------------------------------------
// Path: an accepted word is held in the input register, and a good frame's value
//   is then loaded into the result register.
// Throughput: one word per cycle; a stalled result only holds back a word
//   that itself completes a good frame.
// Reset: synchronous, active high; clears the valid flags and frame state.
module serial_frame_checksum_parser_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sfcp_pkg::BYTE_W-1:0]  rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sfcp_pkg::VALUE_W-1:0] frame_value
);
  import sfcp_pkg::*;

  // Input register stage.
  logic              hold_valid;
  logic [BYTE_W-1:0] hold_byte;

  frame_eval_t eval;
  logic        advance;

  // A word that closes a good frame needs the result register free; any
  // other word moves on regardless of the output side.
  assign advance  = hold_valid && (!eval.hit || !out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  sfcp_frame_track u_track (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (hold_byte),
    .eval    (eval)
  );

  // Control: input and output valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance && eval.hit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: capture the word, load the result.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= rx_byte;
    end
    if (advance && eval.hit) begin
      frame_value <= eval.value;
    end
  end

endmodule

>>> hw/rtl/sfcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcp_checker
// Port-level checks for the framed checksum parser, bound to the top level.
// ----------------------------------------------------------------------------
module sfcp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [sfcp_pkg::BYTE_W-1:0]  rx_byte,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [sfcp_pkg::VALUE_W-1:0] frame_value
);
  import sfcp_pkg::*;

  // A waiting result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_value))
    else $error("result changed while stalled");

  // A waiting input word holds its byte.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(rx_byte))
    else $error("input word changed while stalled");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Input backpressure only comes from a stalled result.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // A fresh result traces back to an accepted input word.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input word");

endmodule

bind serial_frame_checksum_parser_core sfcp_checker u_sfcp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .rx_byte     (rx_byte),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .frame_value (frame_value)
);
